// File: rtl/core/mrpf_pkg.sv
// Shared types and constants for the modem receive payload filter.
// Used by the front end, command queue, back end and top level; depends on nothing.
package mrpf_pkg;

  localparam int LINE_MAX = 64;
  localparam int CNT_W    = 7;
  localparam int PFX_N    = 10;

  localparam logic [15:0] FRAME_MAX = 16'hFFFF;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [79:0] STR_AT         = "AT";
  localparam logic [79:0] STR_OK         = "OK";
  localparam logic [79:0] STR_ERROR      = "ERROR";
  localparam logic [79:0] STR_RDY        = "RDY";
  localparam logic [79:0] STR_CLOSED     = "CLOSED";
  localparam logic [79:0] STR_CONNECT_OK = "CONNECT OK";
  localparam logic [79:0] STR_SEND_OK    = "SEND OK";
  localparam logic [79:0] STR_SEND_FAIL  = "SEND FAIL";

  typedef logic [PFX_N-1:0][7:0] pfx_t;

  // One front-end decision: emit flush_n held bytes, then optionally data.
  typedef struct packed {
    logic [CNT_W-1:0] flush_n;
    logic             has_byte;
    logic [7:0]       data;
  } cmd_t;

  // True when the first k bytes of p spell the leading k characters of s.
  function automatic logic head_is(pfx_t p, logic [79:0] s, logic [3:0] k);
    logic ok;
    int   kk;
    ok = 1'b1;
    kk = int'(k);
    for (int i = 0; i < PFX_N; i++) begin
      if (i < kk && p[i] != s[8*(kk-1-i) +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// File: rtl/core/mrpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/mrpf_front.sv
// Front end: +IPD header tracking, prompt suppression and line classification.
// Depends on mrpf_pkg; writes line bytes into the line RAM, issues cmd_t.
module mrpf_front
  import mrpf_pkg::*;
#(
  parameter int LINE_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  input  logic                          link_up,
  input  logic                          q_full,
  output logic                          q_push,
  output cmd_t                          q_cmd,
  input  logic                          flush_done,
  output logic                          ram_we,
  output logic [$clog2(LINE_BYTES)-1:0] ram_waddr,
  output logic [7:0]                    ram_wdata
);

  typedef enum logic [2:0] {
    H_IDLE, H_I, H_P, H_D, H_COMMA, H_LEN, H_DATA
  } hdr_t;

  hdr_t             hs, hs_next;
  logic [15:0]      flen, flen_next;
  logic [15:0]      fcnt, fcnt_next;
  logic [1:0]       ph, ph_next;
  logic [CNT_W-1:0] lf, lf_next;
  logic [CNT_W-1:0] trim, trim_next;
  pfx_t             pfx, pfx_next;
  logic             flush_wait;

  logic        accept, run_filt, skip, printable, is_ws, starter, ctrl;
  logic [19:0] prod;
  logic [15:0] cnt1;
  cmd_t        cmd;

  assign in_ready  = !q_full && !flush_wait;
  assign accept    = in_valid && in_ready;
  assign ram_waddr = lf[$clog2(LINE_BYTES)-1:0];
  assign ram_wdata = rx_byte;

  always_comb begin
    is_ws = rx_byte == CH_SPACE || rx_byte == CH_CR || rx_byte == CH_LF || rx_byte == CH_TAB;
    printable = rx_byte == CH_CR || rx_byte == CH_LF || rx_byte == CH_TAB ||
                (rx_byte >= CH_SPACE && rx_byte <= CH_TILDE);
    starter = rx_byte == CH_PLUS || rx_byte == "A" || rx_byte == "O" || rx_byte == "E" ||
              rx_byte == "C" || rx_byte == "S" || rx_byte == "R" || rx_byte == "N" ||
              rx_byte == "F";
    ctrl = trim == '0 ||
           (trim >= CNT_W'(2) && head_is(pfx, STR_AT, 4'd2)) ||
           (trim == CNT_W'(2) && head_is(pfx, STR_OK, 4'd2)) ||
           (trim >= CNT_W'(5) && head_is(pfx, STR_ERROR, 4'd5)) ||
           (trim >= CNT_W'(4) && head_is(pfx, STR_RDY, 4'd3)) ||
           (trim >= CNT_W'(7) && head_is(pfx, STR_CLOSED, 4'd6)) ||
           (trim >= CNT_W'(10) && head_is(pfx, STR_CONNECT_OK, 4'd10)) ||
           (trim >= CNT_W'(7) && head_is(pfx, STR_SEND_OK, 4'd7)) ||
           (trim >= CNT_W'(9) && head_is(pfx, STR_SEND_FAIL, 4'd9)) ||
           pfx[0] == CH_GT || pfx[0] == CH_PLUS;

    hs_next   = hs;
    flen_next = flen;
    fcnt_next = fcnt;
    ph_next   = ph;
    lf_next   = lf;
    trim_next = trim;
    pfx_next  = pfx;
    cmd       = '0;
    cmd.data  = rx_byte;
    ram_we    = 1'b0;
    run_filt  = 1'b1;
    skip      = 1'b0;
    prod      = 20'(flen) * 20'd10 + 20'(rx_byte - CH_ZERO);
    cnt1      = fcnt + 16'd1;

    unique case (hs)
      H_IDLE:  if (rx_byte == CH_PLUS) hs_next = H_I;
      H_I:     hs_next = (rx_byte == "I") ? H_P : H_IDLE;
      H_P:     hs_next = (rx_byte == "P") ? H_D : H_IDLE;
      H_D:     hs_next = (rx_byte == "D") ? H_COMMA : H_IDLE;
      H_COMMA: begin
        if (rx_byte == CH_COMMA) begin
          flen_next = '0;
          fcnt_next = '0;
          hs_next   = H_LEN;
        end else begin
          hs_next = H_IDLE;
        end
      end
      H_LEN: begin
        if (is_ws) begin
          hs_next = H_LEN;
        end else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
          flen_next = (prod > 20'(FRAME_MAX)) ? FRAME_MAX : prod[15:0];
        end else if (rx_byte == CH_COLON) begin
          fcnt_next = '0;
          hs_next   = H_DATA;
          run_filt  = 1'b0;
        end else begin
          hs_next = H_IDLE;
        end
      end
      H_DATA: begin
        cmd.has_byte = 1'b1;
        fcnt_next    = cnt1;
        if (cnt1 >= flen) hs_next = H_IDLE;
        run_filt = 1'b0;
      end
      default: hs_next = H_IDLE;
    endcase

    if (run_filt) begin
      if (link_up && ph != 2'd0) begin
        if (ph == 2'd1) begin
          if (rx_byte == CH_CR) begin
            ph_next = 2'd2;
            skip    = 1'b1;
          end else begin
            ph_next = 2'd0;
            skip    = rx_byte == CH_LF;
          end
        end else begin
          ph_next = 2'd0;
          skip    = ph == 2'd2 && rx_byte == CH_LF;
        end
      end
      if (!skip) begin
        if (!printable) begin
          ph_next      = 2'd0;
          cmd.flush_n  = lf;
          cmd.has_byte = link_up;
          lf_next      = '0;
          trim_next    = '0;
        end else if (link_up && lf == '0 && rx_byte == CH_GT) begin
          ph_next = 2'd1;
        end else if (link_up && lf == '0 && (rx_byte == CH_CR || rx_byte == CH_LF)) begin
          ph_next = ph_next;
        end else if (link_up && lf == '0 && !starter) begin
          cmd.has_byte = 1'b1;
        end else if (lf >= CNT_W'(LINE_BYTES - 1)) begin
          cmd.flush_n  = lf;
          cmd.has_byte = link_up;
          lf_next      = '0;
          trim_next    = '0;
        end else begin
          ram_we  = 1'b1;
          if (lf < CNT_W'(PFX_N)) pfx_next[lf[3:0]] = rx_byte;
          lf_next = lf + CNT_W'(1);
          if (!is_ws) trim_next = lf + CNT_W'(1);
          if (rx_byte == CH_LF) begin
            // trailing LF never counts, so the held trim length is final
            if (!ctrl && link_up) cmd.flush_n = lf + CNT_W'(1);
            lf_next   = '0;
            trim_next = '0;
          end
        end
      end
    end

    ram_we = ram_we && accept;
    q_cmd  = cmd;
    q_push = accept && (cmd.flush_n != '0 || cmd.has_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hs         <= H_IDLE;
      flen       <= '0;
      fcnt       <= '0;
      ph         <= 2'd0;
      lf         <= '0;
      trim       <= '0;
      flush_wait <= 1'b0;
    end else begin
      if (accept) begin
        hs   <= hs_next;
        flen <= flen_next;
        fcnt <= fcnt_next;
        ph   <= ph_next;
        lf   <= lf_next;
        trim <= trim_next;
      end
      // hold input until the back end has read the held line out
      if (q_push && cmd.flush_n != '0) flush_wait <= 1'b1;
      else if (flush_done)              flush_wait <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pfx <= pfx_next;
  end

endmodule

// File: rtl/core/mrpf_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on mrpf_pkg for cmd_t.
module mrpf_cmd_fifo
  import mrpf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full    = cnt == 2'd2;
  assign empty   = cnt == 2'd0;
  assign pop_cmd = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_cmd;
  end

endmodule

// File: rtl/core/mrpf_back.sv
// Back end: plays out one command as held-line bytes then any trailing byte.
// Depends on mrpf_pkg; reads the line RAM, drives the output register.
module mrpf_back
  import mrpf_pkg::*;
#(
  parameter int LINE_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  cmd_t                          q_cmd,
  output logic                          q_pop,
  output logic [$clog2(LINE_BYTES)-1:0] ram_raddr,
  input  logic [7:0]                    ram_rdata,
  output logic                          flush_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_last
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DATA, S_BYTE} state_t;

  state_t           state;
  cmd_t             cur;
  logic [CNT_W-1:0] idx;
  logic             out_free, last_read;

  assign out_free   = !out_valid || out_ready;
  assign q_pop      = state == S_IDLE && !q_empty;
  assign ram_raddr  = idx[$clog2(LINE_BYTES)-1:0];
  assign last_read  = idx == cur.flush_n - CNT_W'(1);
  assign flush_done = state == S_DATA && out_free && last_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_cmd;
            idx   <= '0;
            state <= (q_cmd.flush_n != '0) ? S_READ : S_BYTE;
          end
        end
        S_READ: state <= S_DATA;
        S_DATA: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= ram_rdata;
            out_last  <= last_read && !cur.has_byte;
            idx       <= idx + CNT_W'(1);
            if (last_read) state <= cur.has_byte ? S_BYTE : S_IDLE;
            else           state <= S_READ;
          end
        end
        S_BYTE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= cur.data;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/modem_rx_payload_filter_unit.sv
// Channel   Dir  Handshake          tdata              tuser / tlast
// s_        in   s_tvalid/s_tready  [7:0] rx_byte      tuser: link_up
// m_        out  m_tvalid/m_tready  [7:0] payload_byte tlast: last
//
// The front end takes one byte per cycle while no line flush is pending and the
// command queue has room. The back end pops a command in S_IDLE, reads each
// held line byte via S_READ and S_DATA (registered RAM read), then any trailing
// byte in S_BYTE. A pass-through byte passes the queue, command and output
// registers; input stalls from a flush until the last held byte leaves the RAM.
// Synchronous active-high reset clears all control state; RAM needs none.
// Top level: front end, command queue, back end and line RAM.
// Depends on mrpf_pkg, mrpf_front, mrpf_cmd_fifo, mrpf_back, mrpf_ram.
module modem_rx_payload_filter_unit
  import mrpf_pkg::*;
#(
  parameter int LINE_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       s_tuser,   // [0] link_up
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] payload_byte
  output logic       m_tlast
);

  localparam int AW = $clog2(LINE_BYTES);

  cmd_t          push_cmd, pop_cmd;
  logic          push, pop, full, empty, flush_done, we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  mrpf_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .rx_byte(s_tdata), .link_up(s_tuser),
    .q_full(full), .q_push(push), .q_cmd(push_cmd),
    .flush_done,
    .ram_we(we), .ram_waddr(waddr), .ram_wdata(wdata)
  );

  mrpf_cmd_fifo u_fifo (
    .clk, .rst,
    .push, .push_cmd, .full,
    .pop, .pop_cmd, .empty
  );

  mrpf_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk, .rst,
    .q_empty(empty), .q_cmd(pop_cmd), .q_pop(pop),
    .ram_raddr(raddr), .ram_rdata(rdata),
    .flush_done,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_byte(m_tdata), .out_last(m_tlast)
  );

  mrpf_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

endmodule

// File: rtl/core/mrpf_checker.sv
// Port-level checks for modem_rx_payload_filter_unit, bound to the top level.
// No package dependencies.
module mrpf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // reset leaves no transaction pending on the output
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // reset empties the queue and releases the input
  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // a stalled result holds its byte and flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

endmodule

bind modem_rx_payload_filter_unit mrpf_checker u_mrpf_checker (
  .clk, .rst, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);

// File: tb/tb_top.sv
// Testbench for modem_rx_payload_filter_unit: drives modem bytes with link flag,
// predicts payload bytes and tlast, checks them in order.
// Depends on mrpf_pkg and the RTL of the block.
module tb_top;
  import mrpf_pkg::*;

  localparam int LINE_B = 64;
  localparam int WD_LIMIT = 20000;

  typedef enum logic [2:0] {
    HDR_IDLE, HDR_I, HDR_P, HDR_D, HDR_COMMA, HDR_LEN, HDR_DATA
  } hdr_t;

  typedef struct packed {
    logic [7:0] payload;
    logic       last;
  } pay_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  modem_rx_payload_filter_unit #(.LINE_BYTES(LINE_B)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // predictor state
  hdr_t        hdr;
  logic [15:0] frm_len, frm_cnt;
  logic [1:0]  gt_phase;
  int          fill;
  logic [7:0]  held [LINE_B];

  pay_t  pending[$];
  pay_t  step_out[$];
  int    errors = 0;
  int    n_sent = 0, n_got = 0, n_frames = 0;
  bit    rx_idle_on = 1'b1, tx_idle_on = 1'b1;
  int    hold_off = 0;
  int    hold_req = 0, hold_ack = 0;
  int    quiet = 0;

  initial forever #1 clk = ~clk;

  function automatic bit is_ctl_line(int len);
    int n;
    n = len;
    while (n > 0 && (held[n-1] == CH_CR || held[n-1] == CH_LF ||
                     held[n-1] == CH_SPACE || held[n-1] == CH_TAB)) n--;
    if (n == 0) return 1;
    if (n >= 2 && held[0] == "A" && held[1] == "T") return 1;
    if (n == 2 && held[0] == "O" && held[1] == "K") return 1;
    if (n >= 5 && {held[0], held[1], held[2], held[3], held[4]} == "ERROR") return 1;
    if (n >= 4 && {held[0], held[1], held[2]} == "RDY") return 1;
    if (n >= 7 && {held[0], held[1], held[2], held[3], held[4], held[5]} == "CLOSED")
      return 1;
    if (n >= 10 && {held[0], held[1], held[2], held[3], held[4], held[5], held[6],
                    held[7], held[8], held[9]} == "CONNECT OK") return 1;
    if (n >= 7 && {held[0], held[1], held[2], held[3], held[4], held[5], held[6]}
        == "SEND OK") return 1;
    if (n >= 9 && {held[0], held[1], held[2], held[3], held[4], held[5], held[6],
                   held[7], held[8]} == "SEND FAIL") return 1;
    if (held[0] == CH_GT || held[0] == CH_PLUS) return 1;
    return 0;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    if (step_out.size() < 64) step_out.push_back('{payload: b, last: 1'b0});
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < fill; i++) put_byte(held[i]);
    fill = 0;
  endfunction

  function automatic void line_filter(logic [7:0] b, bit up);
    bit prn;
    prn = (b == CH_CR || b == CH_LF || b == CH_TAB || (b >= CH_SPACE && b <= CH_TILDE));
    if (up && gt_phase != 0) begin
      if (gt_phase == 1) begin
        if (b == CH_CR) begin gt_phase = 2; return; end
        gt_phase = 0;
        if (b == CH_LF) return;
      end else if (gt_phase == 2) begin
        gt_phase = 0;
        if (b == CH_LF) return;
      end else gt_phase = 0;
    end
    if (!prn) begin
      gt_phase = 0;
      flush_held();
      if (up) put_byte(b);
      return;
    end
    if (up && fill == 0) begin
      if (b == CH_GT) begin gt_phase = 1; return; end
      if (b == CH_CR || b == CH_LF) return;
      if (!(b inside {"+", "A", "O", "E", "C", "S", "R", "N", "F"})) begin
        put_byte(b);
        return;
      end
    end
    if (fill + 1 >= LINE_B) begin
      flush_held();
      if (up) put_byte(b);
      return;
    end
    held[fill] = b;
    fill++;
    if (b != CH_LF) return;
    if (!is_ctl_line(fill) && up) flush_held();
    fill = 0;
  endfunction

  // Work out the payload caused by one accepted byte and queue it.
  function automatic void predict_payload(logic [7:0] c, bit up);
    step_out.delete();
    case (hdr)
      HDR_IDLE:  if (c == CH_PLUS) hdr = HDR_I;
      HDR_I:     hdr = (c == "I") ? HDR_P : HDR_IDLE;
      HDR_P:     hdr = (c == "P") ? HDR_D : HDR_IDLE;
      HDR_D:     hdr = (c == "D") ? HDR_COMMA : HDR_IDLE;
      HDR_COMMA: begin
        if (c == CH_COMMA) begin
          frm_len = 0; frm_cnt = 0; hdr = HDR_LEN;
        end else hdr = HDR_IDLE;
      end
      HDR_LEN: begin
        if (c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB) begin
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          int unsigned v;
          v = frm_len * 10 + (c - CH_ZERO);
          frm_len = (v > FRAME_MAX) ? FRAME_MAX : v[15:0];
        end else if (c == CH_COLON) begin
          frm_cnt = 0; hdr = HDR_DATA;
        end else hdr = HDR_IDLE;
      end
      HDR_DATA: begin
        pending.push_back('{payload: c, last: 1'b1});
        frm_cnt++;
        if (frm_cnt >= frm_len) begin hdr = HDR_IDLE; n_frames++; end
        return;
      end
      default: hdr = HDR_IDLE;
    endcase
    if (hdr == HDR_DATA) return;
    line_filter(c, up);
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
    foreach (step_out[i]) pending.push_back(step_out[i]);
  endfunction

  // Offer one byte, with an optional random gap ahead of it; valid stays up after
  // the transaction so back-to-back bytes need no second assignment in one step.
  task automatic send_byte(logic [7:0] b, bit up);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= up;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_payload(b, up);
    n_sent++;
  endtask

  task automatic send_text(string t, bit up);
    for (int i = 0; i < t.len(); i++) send_byte(t[i], up);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_off <= 300;
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      hold_off <= $urandom_range(0, 12);
      m_tready <= 1'b0;
    end else m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      pay_t e;
      n_got++;
      if (pending.size() == 0) begin
        $error("payload byte %02h with nothing expected", m_tdata);
        errors++;
      end else begin
        e = pending.pop_front();
        if (m_tdata !== e.payload) begin
          $error("payload_byte expected %02h actual %02h", e.payload, m_tdata);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last expected %0b actual %0b", e.last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_frames();
    send_text("+IPD,3:", 1'b1);
    send_byte(8'h00, 1'b1); send_byte(8'hFF, 1'b1); send_byte(">", 1'b1);
    send_text("+IPD,0:", 1'b0); send_byte("A", 1'b0);
    send_text("+IPD, 1\r\n2:", 1'b1);
    for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_text("+IPD,99999:", 1'b1);
    // the saturated frame stays open; only its first data byte is sent
    send_byte("x", 1'b1);
  endtask

  task automatic test_lines();
    send_text(">\r\n", 1'b1);
    send_text("OK\r\n", 1'b1);
    send_text("SEND OK\r\n", 1'b1);
    send_text("hello\r\n", 1'b1);
    send_text("CLOSED \r\n", 1'b1);
    send_text("Shello\r\n", 1'b0);
    send_text("Ctext", 1'b1); send_byte(8'h01, 1'b1);
    send_text("Cdown", 1'b0); send_byte(8'h80, 1'b0);
  endtask

  // fill past the line capacity, with receiver held off long enough to back up
  task automatic test_overflow();
    hold_req++;
    send_byte("R", 1'b1);
    for (int i = 0; i < 64; i++) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b1);
    send_byte(CH_LF, 1'b1);
    wait_drained();
  endtask

  function automatic logic [7:0] pick_text();
    int    k;
    string starters;
    starters = "AOECSRNF+>";
    k = $urandom_range(0, 9);
    if (k < 6) return 8'($urandom_range(8'h20, 8'h7E));
    if (k == 6) return CH_CR;
    if (k == 7) return CH_LF;
    if (k == 8) return starters[$urandom_range(0, 9)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random(int count, bit quiet_run);
    string words[8];
    int k;
    words = '{"OK", "ERROR x", "RDY ", "CONNECT OK", "SEND FAIL", "AT+X", "Fine", "Nope"};
    tx_idle_on = !quiet_run;
    rx_idle_on = !quiet_run;
    k = 0;
    while (k < count) begin
      case ($urandom_range(0, 3))
        0: begin
          int len;
          len = $urandom_range(0, 6);
          send_text($sformatf("+IPD,%0d:", len), 1'($urandom_range(0, 1)));
          for (int i = 0; i < (len == 0 ? 1 : len); i++)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          k += 8 + len;
        end
        1: begin
          send_text(words[$urandom_range(0, 7)], $urandom_range(0, 3) != 0);
          send_text("\r\n", 1'b1);
          k += 6;
        end
        default: begin
          send_byte(pick_text(), $urandom_range(0, 3) != 0);
          k++;
        end
      endcase
    end
    wait_drained();
  endtask

  initial begin
    hdr = HDR_IDLE; frm_len = 0; frm_cnt = 0; gt_phase = 0; fill = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lines();
    wait_drained();
    test_overflow();
    test_random(10, 1'b0);
    test_random(6, 1'b1);
    test_frames();
    wait_drained();
    $display("Sent %0d bytes, checked %0d payload bytes, %0d complete frames.",
             n_sent, n_got, n_frames);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/mrpf_pkg.sv
rtl/core/mrpf_ram.sv
rtl/core/mrpf_front.sv
rtl/core/mrpf_cmd_fifo.sv
rtl/core/mrpf_back.sv
rtl/core/modem_rx_payload_filter_unit.sv
rtl/core/mrpf_checker.sv
tb/tb_top.sv
